// ===== rtl/set_assoc_cache_policy_engine_assert.svh =====
// Assertion macros for the cache policy engine top level.
`ifndef SET_ASSOC_CACHE_POLICY_ENGINE_ASSERT_SVH
`define SET_ASSOC_CACHE_POLICY_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SACPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SACPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sacpe_pkg.sv =====
// Types and constants shared by the cache policy engine modules.
package sacpe_pkg;

    // Replacement policy codes.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;
    localparam logic [1:0] POL_RAND = 2'd3;

    // Access kind that marks a store.
    localparam logic [1:0] KIND_STORE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_WBMODE = 2'd1;
    localparam logic [1:0] REG_LSIZE  = 2'd2;
    localparam logic [1:0] REG_DECAY  = 2'd3;

    // Galois LFSR feedback mask.
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MODC,
        ST_RD,
        ST_CMP,
        ST_SCAN,
        ST_RND,
        ST_WR,
        ST_DRD,
        ST_DWR
    } t_state;

    // One way of a set as held in the line store.
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] stamp;
    } t_entry;

    // Request to the remainder unit.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_rem_req;

    // Response from the remainder unit.
    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } t_rem_rsp;

endpackage

// ===== rtl/sacpe_rem.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a 16-bit divisor.
module sacpe_rem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sacpe_pkg::t_rem_req i_req,
    output sacpe_pkg::t_rem_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [15:0] r_div;
    logic [15:0] r_rem;
    logic [16:0] trial;
    logic [16:0] diff;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[31]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            trial = diff;
        end
    end

    // Control: 32 steps after a start, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= trial[15:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/set_assoc_cache_policy_engine.sv =====
// Set-associative cache replacement-policy engine, top level.
//
// Each accepted reference makes one or two line accesses, each giving one
// result beat. A line access passes through a read state, a compare state
// and a write-back state, which waits while the result register is full;
// a miss into a full set adds a stamp scan over the ways under FIFO, LRU
// or LFU, or a reciprocal-remainder step under random replacement. An LFU
// decay sweeps the line store with a read and a write per set. Writing a
// nonzero decay interval makes the remainder unit recompute the reference
// count modulo the interval, during which no reference is taken. After
// reset a clearing pass over every set of the line store runs before the
// first reference is taken; configuration writes are taken throughout.
module set_assoc_cache_policy_engine #(
    parameter int ENTRIES = 256,
    parameter int WAYS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Reference channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_access_kind,
    input  logic [31:0] i_address,
    input  logic [6:0]  i_length,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_line_address,
    output logic        o_hit,
    output logic [1:0]  o_way_used,
    output logic        o_dirty_writeback,
    output logic        o_line_fill,
    output logic        o_write_through,
    output logic        o_last
);

    localparam int W        = (WAYS < ENTRIES) ? WAYS : ENTRIES;
    localparam int ROWS     = ENTRIES / W;
    localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WW       = (W > 1) ? $clog2(W) : 1;
    localparam int SET_BITS = $clog2(ROWS + 1) - 1;
    localparam logic [31:0] SET_MASK = 32'((64'd1 << SET_BITS) - 64'd1);
    // Reciprocal of the way count, exact for any 16-bit LFSR value.
    localparam logic [24:0] RECIP = 25'(((64'd1 << 24) + 64'(W) - 64'd1) / 64'(W));

    typedef sacpe_pkg::t_entry [W-1:0] t_row;

    // Configuration registers
    logic [1:0]  r_policy;
    logic        r_wbmode;
    logic [2:0]  r_lsize;
    logic [15:0] r_decay;
    logic        cfg_we;

    // Control state
    sacpe_pkg::t_state r_state, n_state;
    logic [31:0] r_clk, n_clk;
    logic [31:0] r_ref, n_ref;
    logic [15:0] r_mod, n_mod;
    logic        r_mod_stale;
    logic [15:0] r_lfsr, n_lfsr;
    logic [RAW-1:0] r_sw, n_sw;
    logic        r_first, n_first;
    logic        r_ov;

    // Reference and access payload
    logic [31:0] r_la, n_la;
    logic [31:0] r_la1, n_la1;
    logic        r_two, n_two;
    logic        r_store, n_store;
    logic        r_hit, n_hit;
    logic [WW-1:0] r_vic, n_vic;
    logic [WW-1:0] r_idx, n_idx;
    logic [31:0] r_min, n_min;

    // Output register
    logic [31:0] r_o_la;
    logic        r_o_hit;
    logic [1:0]  r_o_way;
    logic        r_o_dwb;
    logic        r_o_fill;
    logic        r_o_wt;
    logic        r_o_last;

    // Line store
    t_row        r_mem [ROWS];
    t_row        r_rd;
    logic        mem_we;
    logic        mem_re;
    logic [RAW-1:0] mem_waddr;
    logic [RAW-1:0] mem_raddr;
    t_row        mem_wdata;

    // Remainder unit
    sacpe_pkg::t_rem_req rem_req;
    sacpe_pkg::t_rem_rsp rem_rsp;

    // Combinational helpers
    logic        accept;
    logic        out_load;
    logic [RAW-1:0] set_idx;
    logic [31:0] lmask;
    logic [6:0]  len0;
    logic [31:0] lastb;
    logic [31:0] la0_c;
    logic [31:0] la1_c;
    logic        hit_c;
    logic [WW-1:0] hit_way;
    logic        inv_c;
    logic [WW-1:0] inv_way;
    logic [15:0] lfsr_step;
    logic        decay_now;
    logic [16:0] mod_inc;
    logic [39:0] rnd_prod;
    logic [15:0] rnd_quot;
    logic [15:0] rnd_rem;
    t_row        row_new;
    t_row        row_half;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Configuration registers and read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= sacpe_pkg::POL_LRU;
            r_wbmode <= 1'b1;
            r_lsize  <= 3'd5;
            r_decay  <= 16'd256;
        end else if (cfg_we) begin
            case (paddr[3:2])
                sacpe_pkg::REG_POLICY: r_policy <= pwdata[1:0];
                sacpe_pkg::REG_WBMODE: r_wbmode <= pwdata[0];
                sacpe_pkg::REG_LSIZE:  r_lsize  <= pwdata[2:0];
                sacpe_pkg::REG_DECAY:  r_decay  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sacpe_pkg::REG_POLICY: prdata = {30'd0, r_policy};
            sacpe_pkg::REG_WBMODE: prdata = {31'd0, r_wbmode};
            sacpe_pkg::REG_LSIZE:  prdata = {29'd0, r_lsize};
            sacpe_pkg::REG_DECAY:  prdata = {16'd0, r_decay};
            default:               prdata = '0;
        endcase
    end

    // Line base addresses of the reference and the set of the current access.
    assign lmask   = ~((32'd1 << r_lsize) - 32'd1);
    assign len0    = (i_length == 7'd0) ? 7'd1 : i_length;
    assign lastb   = i_address + 32'(len0) - 32'd1;
    assign la0_c   = i_address & lmask;
    assign la1_c   = lastb & lmask;
    assign set_idx = RAW'((r_la >> r_lsize) & SET_MASK);

    // Tag compare and first invalid way over the row just read.
    always_comb begin
        hit_c   = 1'b0;
        hit_way = '0;
        inv_c   = 1'b0;
        inv_way = '0;
        for (int i = 0; i < W; i++) begin
            if (!hit_c && r_rd[i].valid && (r_rd[i].tag == r_la)) begin
                hit_c   = 1'b1;
                hit_way = WW'(i);
            end
            if (!inv_c && !r_rd[i].valid) begin
                inv_c   = 1'b1;
                inv_way = WW'(i);
            end
        end
    end

    assign lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ sacpe_pkg::LFSR_MASK) : (r_lfsr >> 1);
    assign decay_now = (r_policy == sacpe_pkg::POL_LFU) && (r_decay != 16'd0) && (r_mod == 16'd0);
    assign mod_inc   = {1'b0, r_mod} + 17'd1;

    // Random victim: the advanced LFSR modulo the way count, by reciprocal multiply.
    assign rnd_prod = {24'd0, r_lfsr} * {15'd0, RECIP};
    assign rnd_quot = rnd_prod[39:24];
    assign rnd_rem  = r_lfsr - 16'(rnd_quot * 16'(W));

    // Updated row for the write-back of a line access.
    always_comb begin
        row_new = r_rd;
        if (r_hit) begin
            if (r_store) begin
                row_new[r_vic].dirty = 1'b1;
            end
            case (r_policy)
                sacpe_pkg::POL_LFU: row_new[r_vic].stamp = r_rd[r_vic].stamp + 32'd1;
                sacpe_pkg::POL_LRU: row_new[r_vic].stamp = r_clk;
                default: ;
            endcase
        end else begin
            row_new[r_vic].valid = 1'b1;
            row_new[r_vic].dirty = r_store;
            row_new[r_vic].tag   = r_la;
            case (r_policy)
                sacpe_pkg::POL_FIFO: row_new[r_vic].stamp = r_ref;
                sacpe_pkg::POL_LFU:  row_new[r_vic].stamp = 32'd0;
                sacpe_pkg::POL_LRU:  row_new[r_vic].stamp = r_clk;
                default: ;
            endcase
        end
    end

    // Row with every stamp halved, for the decay sweep.
    always_comb begin
        row_half = r_rd;
        for (int i = 0; i < W; i++) begin
            row_half[i].stamp = r_rd[i].stamp >> 1;
        end
    end

    assign o_ready  = (r_state == sacpe_pkg::ST_IDLE) && !r_mod_stale;
    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == sacpe_pkg::ST_WR) && (!r_ov || i_ready);

    // Sequencer: next state, memory and remainder-unit controls.
    always_comb begin
        n_state   = r_state;
        n_clk     = r_clk;
        n_ref     = r_ref;
        n_mod     = r_mod;
        n_lfsr    = r_lfsr;
        n_sw      = r_sw;
        n_first   = r_first;
        n_la      = r_la;
        n_la1     = r_la1;
        n_two     = r_two;
        n_store   = r_store;
        n_hit     = r_hit;
        n_vic     = r_vic;
        n_idx     = r_idx;
        n_min     = r_min;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = set_idx;
        mem_raddr = set_idx;
        mem_wdata = row_new;
        rem_req   = '0;
        case (r_state)
            sacpe_pkg::ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sw;
                mem_wdata = '0;
                n_sw      = r_sw + RAW'(1);
                if (r_sw == RAW'(ROWS - 1)) begin
                    n_sw    = '0;
                    n_state = sacpe_pkg::ST_IDLE;
                end
            end
            sacpe_pkg::ST_IDLE: begin
                if (r_mod_stale) begin
                    if (r_decay != 16'd0) begin
                        rem_req.start    = 1'b1;
                        rem_req.dividend = r_ref;
                        rem_req.divisor  = r_decay;
                        n_state          = sacpe_pkg::ST_MODC;
                    end
                end else if (accept) begin
                    n_la    = la0_c;
                    n_la1   = la1_c;
                    n_two   = la0_c != la1_c;
                    n_store = i_access_kind == sacpe_pkg::KIND_STORE;
                    n_first = 1'b1;
                    n_ref   = r_ref + 32'd1;
                    if (n_ref == 32'd0) begin
                        n_mod = '0;
                    end else if (r_decay != 16'd0) begin
                        n_mod = (mod_inc == {1'b0, r_decay}) ? 16'd0 : mod_inc[15:0];
                    end
                    n_state = sacpe_pkg::ST_RD;
                end
            end
            sacpe_pkg::ST_MODC: begin
                if (rem_rsp.done) begin
                    n_mod   = rem_rsp.remainder;
                    n_state = sacpe_pkg::ST_IDLE;
                end
            end
            sacpe_pkg::ST_RD: begin
                mem_re  = 1'b1;
                n_clk   = r_clk + 32'd1;
                n_state = sacpe_pkg::ST_CMP;
            end
            sacpe_pkg::ST_CMP: begin
                n_hit = hit_c;
                if (hit_c) begin
                    n_vic   = hit_way;
                    n_state = sacpe_pkg::ST_WR;
                end else if (inv_c) begin
                    n_vic   = inv_way;
                    n_state = sacpe_pkg::ST_WR;
                end else if (r_policy == sacpe_pkg::POL_RAND) begin
                    n_lfsr  = lfsr_step;
                    n_state = sacpe_pkg::ST_RND;
                end else if (W > 1) begin
                    n_vic   = '0;
                    n_min   = r_rd[0].stamp;
                    n_idx   = WW'(1);
                    n_state = sacpe_pkg::ST_SCAN;
                end else begin
                    n_vic   = '0;
                    n_state = sacpe_pkg::ST_WR;
                end
            end
            sacpe_pkg::ST_SCAN: begin
                // Strict compare keeps the lowest way on a tie.
                if (r_rd[r_idx].stamp < r_min) begin
                    n_min = r_rd[r_idx].stamp;
                    n_vic = r_idx;
                end
                n_idx = r_idx + WW'(1);
                if (r_idx == WW'(W - 1)) begin
                    n_state = sacpe_pkg::ST_WR;
                end
            end
            sacpe_pkg::ST_RND: begin
                n_vic   = WW'(rnd_rem);
                n_state = sacpe_pkg::ST_WR;
            end
            sacpe_pkg::ST_WR: begin
                if (out_load) begin
                    mem_we = 1'b1;
                    if (decay_now) begin
                        n_sw    = '0;
                        n_state = sacpe_pkg::ST_DRD;
                    end else if (r_first && r_two) begin
                        n_first = 1'b0;
                        n_la    = r_la1;
                        n_state = sacpe_pkg::ST_RD;
                    end else begin
                        n_state = sacpe_pkg::ST_IDLE;
                    end
                end
            end
            sacpe_pkg::ST_DRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_sw;
                n_state   = sacpe_pkg::ST_DWR;
            end
            sacpe_pkg::ST_DWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sw;
                mem_wdata = row_half;
                n_sw      = r_sw + RAW'(1);
                n_state   = sacpe_pkg::ST_DRD;
                if (r_sw == RAW'(ROWS - 1)) begin
                    n_sw = '0;
                    if (r_first && r_two) begin
                        n_first = 1'b0;
                        n_la    = r_la1;
                        n_state = sacpe_pkg::ST_RD;
                    end else begin
                        n_state = sacpe_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sacpe_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacpe_pkg::ST_CLR;
            r_clk       <= '0;
            r_ref       <= '0;
            r_mod       <= '0;
            r_mod_stale <= 1'b0;
            r_lfsr      <= 16'd1;
            r_sw        <= '0;
            r_first     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clk   <= n_clk;
            r_ref   <= n_ref;
            r_mod   <= n_mod;
            r_lfsr  <= n_lfsr;
            r_sw    <= n_sw;
            r_first <= n_first;
            // A new interval needs the remainder recomputed before the next beat.
            if (cfg_we && (paddr[3:2] == sacpe_pkg::REG_DECAY)) begin
                r_mod_stale <= 1'b1;
            end else if (r_state == sacpe_pkg::ST_IDLE) begin
                r_mod_stale <= 1'b0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Access payload registers.
    always_ff @(posedge i_clk) begin
        r_la    <= n_la;
        r_la1   <= n_la1;
        r_two   <= n_two;
        r_store <= n_store;
        r_hit   <= n_hit;
        r_vic   <= n_vic;
        r_idx   <= n_idx;
        r_min   <= n_min;
    end

    // Result register, loaded as the line access writes back.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_la   <= r_la;
            r_o_hit  <= r_hit;
            r_o_way  <= 2'(r_vic);
            r_o_dwb  <= !r_hit && r_rd[r_vic].dirty;
            r_o_fill <= !r_hit;
            r_o_wt   <= !r_hit && !r_wbmode && r_store;
            r_o_last <= !(r_first && r_two);
        end
    end

    // Line store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    sacpe_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign o_valid           = r_ov;
    assign o_line_address    = r_o_la;
    assign o_hit             = r_o_hit;
    assign o_way_used        = r_o_way;
    assign o_dirty_writeback = r_o_dwb;
    assign o_line_fill       = r_o_fill;
    assign o_write_through   = r_o_wt;
    assign o_last            = r_o_last;

    `include "set_assoc_cache_policy_engine_assert.svh"

    `SACPE_ASSERT_NXT(a_accept_reads, accept, r_state == sacpe_pkg::ST_RD, "accepted beat did not start a line read")
    `SACPE_ASSERT_IMP(a_clear_blocks, r_state == sacpe_pkg::ST_CLR, !o_ready, "beat offered during clearing pass")
    `SACPE_ASSERT_IMP(a_mod_range, (r_state == sacpe_pkg::ST_IDLE) && !r_mod_stale && (r_decay != 16'd0), r_mod < r_decay, "decay remainder out of range")
    `SACPE_ASSERT_IMP(a_wb_with_result, (r_state == sacpe_pkg::ST_WR) && mem_we, out_load, "line written back without a result beat")

endmodule

// ===== sim/tb_set_assoc_cache_policy_engine.sv =====
// Self-checking testbench for the set-associative cache policy engine.
module tb_set_assoc_cache_policy_engine;

    localparam int NENT  = 256;
    localparam int NWAY  = 4;
    localparam int NSETS = NENT / NWAY;

    // One result beat as predicted or observed.
    typedef struct packed {
        logic [31:0] line_address;
        logic        hit;
        logic [1:0]  way_used;
        logic        dirty_writeback;
        logic        line_fill;
        logic        write_through;
        logic        last;
    } t_line_result;

    // Scoreboard: holds a private copy of the cache state and the queue of
    // line-access results still awaited from the block.
    class cache_scoreboard;
        logic [1:0]   policy;
        logic         wb_mode;
        logic [2:0]   lsize;
        logic [15:0]  decay;
        logic         vbit [NENT];
        logic         dbit [NENT];
        logic [31:0]  tags [NENT];
        logic [31:0]  stamps [NENT];
        logic [31:0]  aclock;
        logic [31:0]  refcnt;
        logic [15:0]  lfsr;
        t_line_result awaited[$];
        int           errors;

        function void clear_state();
            policy  = sacpe_pkg::POL_LRU;
            wb_mode = 1'b1;
            lsize   = 3'd5;
            decay   = 16'd256;
            for (int i = 0; i < NENT; i++) begin
                vbit[i] = 0; dbit[i] = 0; tags[i] = 0; stamps[i] = 0;
            end
            aclock = 0;
            refcnt = 0;
            lfsr   = 16'd1;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                sacpe_pkg::REG_POLICY: policy  = val[1:0];
                sacpe_pkg::REG_WBMODE: wb_mode = val[0];
                sacpe_pkg::REG_LSIZE:  lsize   = val[2:0];
                sacpe_pkg::REG_DECAY:  decay   = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] base_of(logic [31:0] a);
            return a & ~((32'd1 << lsize) - 32'd1);
        endfunction

        // Halve every frequency stamp when the reference count is a multiple of the period.
        function void maybe_decay();
            if (policy != sacpe_pkg::POL_LFU || decay == 0) return;
            if (refcnt % decay != 0) return;
            for (int i = 0; i < NENT; i++) stamps[i] = stamps[i] >> 1;
        endfunction

        function int choose_victim(int base);
            int v;
            logic [31:0] m;
            for (int i = 0; i < NWAY; i++)
                if (!vbit[base + i]) return base + i;
            if (policy == sacpe_pkg::POL_RAND) begin
                logic b;
                b = lfsr[0];
                lfsr = lfsr >> 1;
                if (b) lfsr = lfsr ^ sacpe_pkg::LFSR_MASK;
                return base + (lfsr % NWAY);
            end
            v = base;
            m = stamps[base];
            for (int i = 1; i < NWAY; i++)
                if (stamps[base + i] < m) begin
                    v = base + i;
                    m = stamps[v];
                end
            return v;
        endfunction

        function void access_line(logic [31:0] addr, logic store, logic fin);
            t_line_result r;
            logic [31:0] la;
            int base, v;
            la = base_of(addr);
            base = ((la >> lsize) & (NSETS - 1)) * NWAY;
            aclock++;
            r = '0;
            r.line_address = la;
            r.last = fin;
            for (int i = 0; i < NWAY; i++) begin
                if (vbit[base + i] && tags[base + i] == la) begin
                    if (store) dbit[base + i] = 1;
                    if (policy == sacpe_pkg::POL_LFU) begin
                        stamps[base + i]++;
                        maybe_decay();
                    end else if (policy == sacpe_pkg::POL_LRU) begin
                        stamps[base + i] = aclock;
                    end
                    r.hit = 1;
                    r.way_used = 2'(i);
                    awaited.push_back(r);
                    return;
                end
            end
            v = choose_victim(base);
            r.way_used = 2'(v - base);
            r.dirty_writeback = dbit[v];
            r.line_fill = 1;
            r.write_through = !wb_mode && store;
            vbit[v] = 1;
            tags[v] = la;
            dbit[v] = store;
            if (policy == sacpe_pkg::POL_FIFO) stamps[v] = refcnt;
            else if (policy == sacpe_pkg::POL_LFU) begin
                stamps[v] = 0;
                maybe_decay();
            end else if (policy == sacpe_pkg::POL_LRU) stamps[v] = aclock;
            awaited.push_back(r);
        endfunction

        // Note an accepted reference and queue the line accesses it causes.
        function void note_reference(logic [1:0] kind, logic [31:0] addr, logic [6:0] len);
            logic [31:0] lastb;
            logic [6:0]  n;
            logic        store;
            store = (kind == sacpe_pkg::KIND_STORE);
            n = (len == 0) ? 7'd1 : len;
            lastb = addr + 32'(n) - 32'd1;
            refcnt++;
            if (base_of(addr) == base_of(lastb)) begin
                access_line(addr, store, 1'b1);
            end else begin
                access_line(addr, store, 1'b0);
                access_line(base_of(lastb), store, 1'b1);
            end
        endfunction

        function void check_beat(t_line_result got);
            t_line_result exp;
            if (awaited.size() == 0) begin
                $error("unexpected result beat, line_address %h", got.line_address);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.line_address != exp.line_address) begin
                $error("line_address expected %h actual %h", exp.line_address, got.line_address);
                errors++;
            end
            if (got.hit != exp.hit) begin
                $error("hit expected %0d actual %0d", exp.hit, got.hit);
                errors++;
            end
            if (got.way_used != exp.way_used) begin
                $error("way_used expected %0d actual %0d", exp.way_used, got.way_used);
                errors++;
            end
            if (got.dirty_writeback != exp.dirty_writeback) begin
                $error("dirty_writeback expected %0d actual %0d",
                       exp.dirty_writeback, got.dirty_writeback);
                errors++;
            end
            if (got.line_fill != exp.line_fill) begin
                $error("line_fill expected %0d actual %0d", exp.line_fill, got.line_fill);
                errors++;
            end
            if (got.write_through != exp.write_through) begin
                $error("write_through expected %0d actual %0d",
                       exp.write_through, got.write_through);
                errors++;
            end
            if (got.last != exp.last) begin
                $error("last expected %0d actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_access_kind = 0;
    logic [31:0] i_address = 0;
    logic [6:0]  i_length = 1;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_line_address;
    logic        o_hit;
    logic [1:0]  o_way_used;
    logic        o_dirty_writeback, o_line_fill, o_write_through, o_last;

    cache_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;

    set_assoc_cache_policy_engine #(.ENTRIES(NENT), .WAYS(NWAY)) dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: checks every beat at the rising edge, changes ready at the falling one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_beat({o_line_address, o_hit, o_way_used, o_dirty_writeback,
                           o_line_fill, o_write_through, o_last});
    end

    always @(negedge i_clk) begin
        i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Register write with a setup and an access phase, applied to the prediction at the write edge.
    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, val);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one reference and hold it until the block takes it.
    task automatic send_reference(logic [1:0] kind, logic [31:0] addr, logic [6:0] len);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_access_kind <= kind; i_address <= addr; i_length <= len;
        do @(posedge i_clk); while (!o_ready);
        sb.note_reference(kind, addr, len);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    // Wait for the last awaited beat, then let the block settle.
    task automatic drain();
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random references: mostly lines from a small pool so sets fill and hit.
    task automatic random_references(int count);
        logic [31:0] a;
        logic [6:0]  n;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: a = $urandom();
                1, 2: a = 32'({2'($urandom_range(3)), 6'd0, 8'($urandom_range(255))}) << 4;
                default: a = ($urandom_range(15) << 13) | ($urandom_range(63) << 7)
                             | $urandom_range(127);
            endcase
            n = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
            send_reference(2'($urandom_range(3)), a, n);
        end
    endtask

    initial begin
        #50000000;
        $display("tb_set_assoc_cache_policy_engine failed");
        $finish;
    end

    initial begin
        sb.clear_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes of fields, every kind, line crossings, wrap at top.
        send_reference(2'd0, 32'h0, 7'd1);
        send_reference(2'd1, 32'h0, 7'd0);
        send_reference(2'd2, 32'h1F, 7'd2);
        send_reference(2'd3, 32'hFFFF_FFFF, 7'd64);
        send_reference(2'd2, 32'hFFFF_FFF0, 7'd127);
        send_reference(2'd1, 32'hAAAA_5555, 7'h55);
        send_reference(2'd2, 32'h5555_AAAA, 7'h2A);
        for (int k = 0; k < 6; k++) send_reference(2'd2, 32'(k << 11), 7'd4);
        for (int k = 0; k < 6; k++) send_reference(2'd1, 32'(k << 11), 7'd4);
        drain();

        // Each phase: new settings for some or all registers, then random references.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_FIFO));
                         write_register(sacpe_pkg::REG_WBMODE, 32'd0);
                         write_register(sacpe_pkg::REG_LSIZE, 32'd0);
                         write_register(sacpe_pkg::REG_DECAY, 32'd1); end
                1: begin write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_LFU));
                         write_register(sacpe_pkg::REG_DECAY, 32'd3);
                         write_register(sacpe_pkg::REG_LSIZE, 32'd7); end
                2: begin write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_RAND));
                         write_register(sacpe_pkg::REG_WBMODE, 32'd1);
                         write_register(sacpe_pkg::REG_LSIZE, 32'd4); end
                3: begin write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_LFU));
                         write_register(sacpe_pkg::REG_DECAY, 32'h0000_FFFF); end
                4: begin write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_LRU));
                         write_register(sacpe_pkg::REG_LSIZE, 32'd6); end
                5: begin write_register(sacpe_pkg::REG_DECAY, 32'd0);
                         write_register(sacpe_pkg::REG_POLICY, 32'(sacpe_pkg::POL_LFU)); end
                default: begin
                    write_register(sacpe_pkg::REG_POLICY, $urandom_range(3));
                    write_register(sacpe_pkg::REG_WBMODE, $urandom_range(1));
                    write_register(sacpe_pkg::REG_LSIZE, $urandom_range(7));
                    write_register(sacpe_pkg::REG_DECAY, $urandom_range(9) == 0 ?
                                   $urandom_range(65535) : $urandom_range(40, 1));
                end
            endcase
            send_idle_pct = (ph < 4) ? 36 : (ph < 8) ? 64 : 0;
            recv_idle_pct = (ph < 4) ? 64 : (ph < 8) ? 36 : 0;
            if (ph == 9) begin
                // Receiver holds off long enough for the block to stall its input.
                fork
                    begin
                        recv_hold = 1;
                        repeat (400) @(posedge i_clk);
                        recv_hold = 0;
                    end
                    random_references(160);
                join
            end else begin
                random_references(160);
            end
            drain();
        end

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_set_assoc_cache_policy_engine passed");
        else
            $display("tb_set_assoc_cache_policy_engine failed");
        $finish;
    end
endmodule

// ===== set_assoc_cache_policy_engine.f =====
+incdir+rtl
rtl/sacpe_pkg.sv
rtl/sacpe_rem.sv
rtl/set_assoc_cache_policy_engine.sv
sim/tb_set_assoc_cache_policy_engine.sv
